/* rtl/core/r2q_pkg.sv */
// Shared types for the rotation matrix to quaternion pipeline.
// No dependencies.
package r2q_pkg;

    // Which component comes from the square root.
    typedef enum logic [1:0] {
        AX_TRACE = 2'd0,
        AX_X     = 2'd1,
        AX_Y     = 2'd2,
        AX_Z     = 2'd3
    } ax_t;

endpackage

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Rotation matrix (signed Q.FRAC_BITS) to unit quaternion, fully pipelined.
// Depends on r2q_pkg, r2q_front, r2q_isqrt, r2q_div.
//
// Input channel: in_valid/in_ready carry the nine elements m00..m22 as one beat.
// Output channel: out_valid/out_ready carry quat_w..quat_z and degenerate.
// The root has SW = ceil((RW + FRAC_BITS) / 2) bits and the quotients
// NW = max(DATA_WIDTH + 1 + FRAC_BITS, SW) + 1 bits, where
// RW = max(DATA_WIDTH, FRAC_BITS + 1) + 3.
// One stage front end, one root bit per stage, one numerator stage, one
// quotient bit per stage in three parallel lanes, one output register.
// Throughput is one beat per cycle while the receiver does not stall.
// The whole pipeline advances together; when the receiver holds out_ready
// low with a beat waiting, every stage and in_ready hold, so nothing is
// lost or repeated. Reset clears all stage valid bits; out_valid is low
// and in_ready is high after reset.
// A zero or negative radicand gives all-zero components and degenerate high.
module rotation_matrix_to_quaternion
    import r2q_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] m00,
    input  logic signed [DATA_WIDTH-1:0] m01,
    input  logic signed [DATA_WIDTH-1:0] m02,
    input  logic signed [DATA_WIDTH-1:0] m10,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m20,
    input  logic signed [DATA_WIDTH-1:0] m21,
    input  logic signed [DATA_WIDTH-1:0] m22,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] quat_w,
    output logic signed [DATA_WIDTH-1:0] quat_x,
    output logic signed [DATA_WIDTH-1:0] quat_y,
    output logic signed [DATA_WIDTH-1:0] quat_z,
    output logic                         degenerate
);

    localparam int W   = DATA_WIDTH;
    localparam int DDW = W + 1;
    localparam int RW  = ((W > FRAC_BITS + 1) ? W : FRAC_BITS + 1) + 3;
    localparam int SW  = (RW + FRAC_BITS + 1) / 2;
    localparam int NBW = 2 * SW;
    localparam int NW  = ((DDW + FRAC_BITS > SW) ? DDW + FRAC_BITS : SW) + 1;
    localparam int DW  = SW + 1;
    localparam int PW1 = 3 * DDW + 3;
    localparam int PW2 = SW + 6;
    localparam logic [NW-1:0] POS_LIM = NW'(1) << (W - 1);
    localparam logic [NW-1:0] MAG_MAX = POS_LIM - NW'(1);

    function automatic logic [W-1:0] sat_mag(input logic [NW-1:0] q, input logic neg);
        logic [W-1:0] r;
        if (neg)
            r = (q >= POS_LIM) ? POS_LIM[W-1:0] : (~q[W-1:0] + 1'b1);
        else
            r = (q > MAG_MAX) ? MAG_MAX[W-1:0] : q[W-1:0];
        return r;
    endfunction

    logic                  en;
    logic                  f_vld;
    logic [NBW-1:0]        f_n;
    logic signed [DDW-1:0] f_d0, f_d1, f_d2;
    ax_t                   f_ax;
    logic                  f_degen;

    logic                  s_vld;
    logic [SW-1:0]         s_root;
    logic [PW1-1:0]        s_side;
    logic [2:0][DDW-1:0]   s_d;
    ax_t                   s_ax;
    logic                  s_degen;

    logic [2:0][NW-1:0]    p_num_next;
    logic [2:0]            p_sign_next;
    logic [DDW-1:0]        mag;
    logic                  p_vld_reg;
    logic [2:0][NW-1:0]    p_num_reg;
    logic [DW-1:0]         p_den_reg;
    logic [PW2-1:0]        p_side_reg;

    logic                  q_vld;
    logic [2:0][NW-1:0]    q_quo;
    logic [PW2-1:0]        q_side;
    logic [SW-1:0]         q_root;
    logic [2:0]            q_sign;
    ax_t                   q_ax;
    logic                  q_degen;
    logic [W-1:0]          c_root, c0, c1, c2;
    logic [W-1:0]          w_next, x_next, y_next, z_next;

    logic                  out_valid_reg;
    logic [W-1:0]          w_reg, x_reg, y_reg, z_reg;
    logic                  degen_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    r2q_front #(
        .DATA_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS),
        .RW         (RW),
        .NBW        (NBW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .m00      (m00),
        .m01      (m01),
        .m02      (m02),
        .m10      (m10),
        .m11      (m11),
        .m12      (m12),
        .m20      (m20),
        .m21      (m21),
        .m22      (m22),
        .vld      (f_vld),
        .n        (f_n),
        .d0       (f_d0),
        .d1       (f_d1),
        .d2       (f_d2),
        .ax       (f_ax),
        .degen    (f_degen)
    );

    r2q_isqrt #(
        .SW (SW),
        .PW (PW1)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .n        (f_n),
        .side_in  ({f_degen, f_ax, f_d2, f_d1, f_d0}),
        .vld      (s_vld),
        .root     (s_root),
        .side_out (s_side)
    );

    assign s_d[0]  = s_side[DDW-1:0];
    assign s_d[1]  = s_side[2*DDW-1:DDW];
    assign s_d[2]  = s_side[3*DDW-1:2*DDW];
    assign s_ax    = ax_t'(s_side[3*DDW+1:3*DDW]);
    assign s_degen = s_side[3*DDW+2];

    always_comb
    begin
        mag = '0;
        for (int l = 0; l < 3; l++)
        begin
            p_sign_next[l] = s_d[l][DDW-1];
            mag            = p_sign_next[l] ? (~s_d[l] + 1'b1) : s_d[l];
            p_num_next[l]  = (NW'(mag) << FRAC_BITS) + NW'(s_root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= s_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_num_reg  <= p_num_next;
            p_den_reg  <= {s_root, 1'b0};
            p_side_reg <= {s_degen, s_ax, p_sign_next, s_root};
        end
    end

    r2q_div #(
        .NW (NW),
        .DW (DW),
        .PW (PW2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p_vld_reg),
        .num      (p_num_reg),
        .den      (p_den_reg),
        .side_in  (p_side_reg),
        .vld      (q_vld),
        .quo      (q_quo),
        .side_out (q_side)
    );

    assign q_root  = q_side[SW-1:0];
    assign q_sign  = q_side[SW+2:SW];
    assign q_ax    = ax_t'(q_side[SW+4:SW+3]);
    assign q_degen = q_side[SW+5];

    always_comb
    begin
        c_root = sat_mag((NW'(q_root) + NW'(1)) >> 1, 1'b0);
        c0     = sat_mag(q_quo[0], q_sign[0]);
        c1     = sat_mag(q_quo[1], q_sign[1]);
        c2     = sat_mag(q_quo[2], q_sign[2]);
        unique case (q_ax)
            AX_TRACE:
            begin
                w_next = c_root; x_next = c0; y_next = c1; z_next = c2;
            end
            AX_X:
            begin
                w_next = c0; x_next = c_root; y_next = c1; z_next = c2;
            end
            AX_Y:
            begin
                w_next = c0; x_next = c2; y_next = c_root; z_next = c1;
            end
            default:
            begin
                w_next = c0; x_next = c1; y_next = c2; z_next = c_root;
            end
        endcase
        if (q_degen)
        begin
            w_next = '0; x_next = '0; y_next = '0; z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= q_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= w_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            degen_reg <= q_degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign quat_w     = w_reg;
    assign quat_x     = x_reg;
    assign quat_y     = y_reg;
    assign quat_z     = z_reg;
    assign degenerate = degen_reg;

endmodule

/* rtl/core/r2q_front.sv */
// Input stage: trace, axis pick, radicand and off-diagonal sums/differences.
// Depends on r2q_pkg.
module r2q_front
    import r2q_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int RW         = 19,
    parameter int NBW        = 34
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [DATA_WIDTH-1:0] m00,
    input  logic signed [DATA_WIDTH-1:0] m01,
    input  logic signed [DATA_WIDTH-1:0] m02,
    input  logic signed [DATA_WIDTH-1:0] m10,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m20,
    input  logic signed [DATA_WIDTH-1:0] m21,
    input  logic signed [DATA_WIDTH-1:0] m22,
    output logic                         vld,
    output logic [NBW-1:0]               n,
    output logic signed [DATA_WIDTH:0]   d0,
    output logic signed [DATA_WIDTH:0]   d1,
    output logic signed [DATA_WIDTH:0]   d2,
    output ax_t                          ax,
    output logic                         degen
);

    localparam int DDW = DATA_WIDTH + 1;
    localparam logic signed [RW-1:0] ONE = RW'(1) << FRAC_BITS;

    logic signed [RW-1:0]  e00, e11, e22, trace, rad;
    logic signed [DDW-1:0] d0_next, d1_next, d2_next;
    ax_t                   ax_next;
    logic                  degen_next;
    logic [NBW-1:0]        n_next;
    logic                  vld_reg;
    logic [NBW-1:0]        n_reg;
    logic signed [DDW-1:0] d0_reg, d1_reg, d2_reg;
    ax_t                   ax_reg;
    logic                  degen_reg;

    always_comb
    begin
        e00   = RW'(m00);
        e11   = RW'(m11);
        e22   = RW'(m22);
        trace = e00 + e11 + e22;
        if (trace > 0)
        begin
            ax_next = AX_TRACE;
        end
        else
        begin
            ax_next = AX_X;
            if (m11 > m00)
                ax_next = AX_Y;
            if (m22 > ((ax_next == AX_Y) ? m11 : m00))
                ax_next = AX_Z;
        end
        unique case (ax_next)
            AX_TRACE:
            begin
                rad     = ONE + trace;
                d0_next = DDW'(m21) - DDW'(m12);
                d1_next = DDW'(m02) - DDW'(m20);
                d2_next = DDW'(m10) - DDW'(m01);
            end
            AX_X:
            begin
                rad     = ONE + e00 - e11 - e22;
                d0_next = DDW'(m21) - DDW'(m12);
                d1_next = DDW'(m10) + DDW'(m01);
                d2_next = DDW'(m20) + DDW'(m02);
            end
            AX_Y:
            begin
                rad     = ONE + e11 - e22 - e00;
                d0_next = DDW'(m02) - DDW'(m20);
                d1_next = DDW'(m21) + DDW'(m12);
                d2_next = DDW'(m01) + DDW'(m10);
            end
            default:
            begin
                rad     = ONE + e22 - e00 - e11;
                d0_next = DDW'(m10) - DDW'(m01);
                d1_next = DDW'(m02) + DDW'(m20);
                d2_next = DDW'(m12) + DDW'(m21);
            end
        endcase
        degen_next = (ax_next != AX_TRACE) && (rad <= 0);
        n_next     = degen_next ? '0 : (NBW'(rad[RW-1:0]) << FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= n_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            ax_reg    <= ax_next;
            degen_reg <= degen_next;
        end
    end

    assign vld   = vld_reg;
    assign n     = n_reg;
    assign d0    = d0_reg;
    assign d1    = d1_reg;
    assign d2    = d2_reg;
    assign ax    = ax_reg;
    assign degen = degen_reg;

endmodule

/* rtl/core/r2q_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
// No dependencies.
module r2q_isqrt
#(
    parameter int SW = 17,
    parameter int PW = 54
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [2*SW-1:0] n,
    input  logic [PW-1:0]   side_in,
    output logic            vld,
    output logic [SW-1:0]   root,
    output logic [PW-1:0]   side_out
);

    localparam int RMW = SW + 2;

    logic [SW-1:0]            vld_reg;
    logic [SW-1:0][RMW-1:0]   rem_reg;
    logic [SW-1:0][SW-1:0]    root_reg;
    logic [SW-1:0][2*SW-1:0]  nsh_reg;
    logic [SW-1:0][PW-1:0]    side_reg;

    for (genvar g = 0; g < SW; g++)
    begin : g_stage
        logic            v_in;
        logic [RMW-1:0]  rem_in, remc, trial, rem_next;
        logic [SW-1:0]   root_in, root_next;
        logic [2*SW-1:0] n_in;
        logic [PW-1:0]   s_in;
        logic            ge;

        if (g == 0)
        begin : g_first
            assign v_in    = in_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = n;
            assign s_in    = side_in;
        end
        else
        begin : g_rest
            assign v_in    = vld_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign n_in    = nsh_reg[g-1];
            assign s_in    = side_reg[g-1];
        end

        always_comb
        begin
            remc      = {rem_in[RMW-3:0], n_in[2*SW-1:2*SW-2]};
            trial     = {root_in, 2'b01};
            ge        = (remc >= trial);
            rem_next  = ge ? (remc - trial) : remc;
            root_next = {root_in[SW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (en)
                vld_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                nsh_reg[g]  <= n_in << 2;
                side_reg[g] <= s_in;
            end
        end
    end

    assign vld      = vld_reg[SW-1];
    assign root     = root_reg[SW-1];
    assign side_out = side_reg[SW-1];

endmodule

/* rtl/core/r2q_div.sv */
// Pipelined restoring divider, three lanes over a shared divisor,
// one quotient bit per stage. No dependencies.
module r2q_div
#(
    parameter int NW = 32,
    parameter int DW = 18,
    parameter int PW = 23
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [2:0][NW-1:0]  num,
    input  logic [DW-1:0]       den,
    input  logic [PW-1:0]       side_in,
    output logic                vld,
    output logic [2:0][NW-1:0]  quo,
    output logic [PW-1:0]       side_out
);

    logic [NW-1:0]                vld_reg;
    logic [NW-1:0][2:0][DW-1:0]   rem_reg;
    logic [NW-1:0][2:0][NW-1:0]   nq_reg;
    logic [NW-1:0][DW-1:0]        den_reg;
    logic [NW-1:0][PW-1:0]        side_reg;

    for (genvar g = 0; g < NW; g++)
    begin : g_stage
        logic                v_in;
        logic [2:0][DW-1:0]  rem_in, rem_next;
        logic [2:0][NW-1:0]  nq_in, nq_next;
        logic [DW-1:0]       d_in;
        logic [PW-1:0]       s_in;
        logic [DW:0]         remc, diff;

        if (g == 0)
        begin : g_first
            assign v_in   = in_vld;
            assign rem_in = '0;
            assign nq_in  = num;
            assign d_in   = den;
            assign s_in   = side_in;
        end
        else
        begin : g_rest
            assign v_in   = vld_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign nq_in  = nq_reg[g-1];
            assign d_in   = den_reg[g-1];
            assign s_in   = side_reg[g-1];
        end

        always_comb
        begin
            remc = '0;
            diff = '0;
            for (int l = 0; l < 3; l++)
            begin
                remc = {rem_in[l], nq_in[l][NW-1]};
                diff = remc - {1'b0, d_in};
                if (remc >= {1'b0, d_in})
                begin
                    rem_next[l] = diff[DW-1:0];
                    nq_next[l]  = {nq_in[l][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = remc[DW-1:0];
                    nq_next[l]  = {nq_in[l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (en)
                vld_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                nq_reg[g]   <= nq_next;
                den_reg[g]  <= d_in;
                side_reg[g] <= s_in;
            end
        end
    end

    assign vld      = vld_reg[NW-1];
    assign quo      = nq_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule

/* rtl/core/r2q_checker.sv */
// Port-level checks for rotation_matrix_to_quaternion, bound to the top level.
// Depends on rotation_matrix_to_quaternion.
module r2q_checker
#(
    parameter int DATA_WIDTH = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] quat_w,
    input logic signed [DATA_WIDTH-1:0] quat_x,
    input logic signed [DATA_WIDTH-1:0] quat_y,
    input logic signed [DATA_WIDTH-1:0] quat_z,
    input logic                         degenerate
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |->
            quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0)
        else $error("degenerate beat with nonzero components");

    a_axis_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |->
            quat_w > 0 || quat_x > 0 || quat_y > 0 || quat_z > 0)
        else $error("no positive root component");

endmodule

bind rotation_matrix_to_quaternion r2q_checker #(.DATA_WIDTH(DATA_WIDTH)) u_r2q_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for rotation_matrix_to_quaternion: drives matrices, predicts quaternions
// with an internal fixed-point model and checks every output beat in order.
// Depends on r2q_pkg and the RTL of the block.
module tb_top;
    import r2q_pkg::*;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int LATENCY = 52;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic signed [DW-1:0] elem_t;

    typedef struct {
        elem_t w;
        elem_t x;
        elem_t y;
        elem_t z;
        logic  degen;
    } quat_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic  out_valid;
    logic  out_ready;
    elem_t quat_w, quat_x, quat_y, quat_z;
    logic  degenerate;

    quat_t quat_queue[$];
    int    error_count = 0;
    int    idle_cycles = 0;
    bit    calm;

    rotation_matrix_to_quaternion DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .m00(m00), .m01(m01), .m02(m02),
        .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint div_by_root(longint d, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((mag << FB) + s) / (2 * s);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic elem_t clamp(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return elem_t'(v);
    endfunction

    function automatic quat_t matrix_to_quat(elem_t a[9]);
        longint m[3][3];
        longint q[4];
        longint tr;
        longint rad;
        longint unsigned s;
        int i, j, k;
        quat_t res;
        for (int n = 0; n < 9; n++)
            m[n / 3][n % 3] = a[n];
        q = '{0, 0, 0, 0};
        res.degen = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            rad = (64'sd1 << FB) + tr;
            s = int_sqrt(longint'(rad) << FB);
            q[0] = longint'((s + 1) >> 1);
            q[1] = div_by_root(m[2][1] - m[1][2], s);
            q[2] = div_by_root(m[0][2] - m[2][0], s);
            q[3] = div_by_root(m[1][0] - m[0][1], s);
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = (64'sd1 << FB) + m[i][i] - m[j][j] - m[k][k];
            if (rad <= 0)
                res.degen = 1'b1;
            else
            begin
                s = int_sqrt(longint'(rad) << FB);
                q[1 + i] = longint'((s + 1) >> 1);
                q[0] = div_by_root(m[k][j] - m[j][k], s);
                q[1 + j] = div_by_root(m[j][i] + m[i][j], s);
                q[1 + k] = div_by_root(m[k][i] + m[i][k], s);
            end
        end
        res.w = clamp(q[0]);
        res.x = clamp(q[1]);
        res.y = clamp(q[2]);
        res.z = clamp(q[3]);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_matrix(elem_t a[9]);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        m00 <= a[0]; m01 <= a[1]; m02 <= a[2];
        m10 <= a[3]; m11 <= a[4]; m12 <= a[5];
        m20 <= a[6]; m21 <= a[7]; m22 <= a[8];
        quat_queue.push_back(matrix_to_quat(a));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // receiver stalls in bursts
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            hold = $urandom_range(1, 30);
            repeat (hold) @(posedge clk);
            if (!calm)
            begin
                out_ready <= 1'b0;
                hold = $urandom_range(1, 15);
                repeat (hold) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (quat_queue.size() == 0)
            begin
                $display("unexpected output beat at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = quat_queue.pop_front();
                if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
                if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
                if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
                if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
                if (degenerate !== want.degen)
                    report_mismatch("degenerate", degenerate, want.degen);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 3))
            0: return elem_t'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return elem_t'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // approximate rotation from small-angle style perturbation of a signed permutation
    function automatic void make_rotation(output elem_t a[9]);
        int p;
        int sg;
        p = $urandom_range(0, 5);
        for (int n = 0; n < 9; n++)
            a[n] = elem_t'(int'($urandom_range(0, 4000)) - 2000);
        for (int r = 0; r < 3; r++)
        begin
            sg = $urandom_range(0, 1) ? 1 : -1;
            a[r * 3 + (r + p) % 3] = elem_t'(sg * int'($urandom_range(9000, 16384)));
        end
    endfunction

    task automatic test_directed();
        elem_t a[9];
        a = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};  send_matrix(a);
        a = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(a);
        a = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(a);
        a = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(a);
        a = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};  send_matrix(a);
        a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};               send_matrix(a);
        a = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(a);
        a = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(a);
        a = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(a);
        a = '{1, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -1}; send_matrix(a);
        a = '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};       send_matrix(a);
        a = '{-5, 0, 0, 0, -5, 0, 0, 0, 1};             send_matrix(a);
        a = '{0, 100, 0, 100, 0, 0, 0, 0, 0};           send_matrix(a);
        a = '{-1, 32767, 32767, -32768, -1, 32767, 32767, 32767, -1}; send_matrix(a);
        a = '{-16384, 0, 0, 0, 0, 0, 0, 0, 16383};      send_matrix(a);
    endtask

    task automatic test_rotations(int count);
        elem_t a[9];
        for (int n = 0; n < count; n++)
        begin
            make_rotation(a);
            send_matrix(a);
        end
    endtask

    task automatic test_noise(int count);
        elem_t a[9];
        for (int n = 0; n < count; n++)
        begin
            foreach (a[e])
                a[e] = rand_elem();
            send_matrix(a);
        end
    endtask

    task automatic test_back_to_back(int count);
        calm = 1'b1;
        test_rotations(count / 2);
        test_noise(count - count / 2);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_rotations(700);
        test_noise(300);
        test_back_to_back(200);
        in_valid <= 1'b0;
        while (quat_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
